// ===== sv/hzd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hzd_pkg: shared types and constants of the register hazard detector
// Access kinds, hazard codes, the instruction word passed from front to back,
// the result word and the stream field layout.
// ----------------------------------------------------------------------------
package hzd_pkg;

  localparam int DEF_NUM_REGS   = 32;
  localparam int DEF_INDEX_BITS = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int REG_W      = 5;
  localparam int OUT_IDX_W  = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - REG_W - 2 * OUT_IDX_W;

  // input word bit positions
  localparam int IN_A_VLD = 0;
  localparam int IN_A_REG = 1;
  localparam int IN_B_VLD = 6;
  localparam int IN_B_REG = 7;
  localparam int IN_D_VLD = 12;
  localparam int IN_D_REG = 13;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } acc_kind_t;

  typedef enum logic [1:0] {
    HZ_RAW = 2'd0,
    HZ_WAR = 2'd1,
    HZ_WAW = 2'd2
  } hz_kind_t;

  typedef enum logic [1:0] {
    SLOT_A = 2'd0,
    SLOT_B = 2'd1,
    SLOT_D = 2'd2
  } slot_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EVAL,
    BK_FLUSH
  } back_state_t;

  // en[0] source A, en[1] source B, en[2] destination; set only when in range
  typedef struct packed {
    logic [2:0]       en;
    logic [REG_W-1:0] dst;
    logic [REG_W-1:0] src_b;
    logic [REG_W-1:0] src_a;
  } instr_t;

  typedef struct packed {
    hz_kind_t             kind;
    logic [REG_W-1:0]     hreg;
    logic [OUT_IDX_W-1:0] earlier;
    logic [OUT_IDX_W-1:0] later;
    logic                 last;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/hzd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hzd_front: instruction intake
// Unpacks the input word, drops accesses to registers beyond the file and
// pushes the classified instruction into the queue.
// ----------------------------------------------------------------------------
module hzd_front #(
  parameter int NUM_REGS = hzd_pkg::DEF_NUM_REGS
) (
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [hzd_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                          q_ready,
  output logic                               q_push,
  output hzd_pkg::instr_t                    q_word
);

  logic [hzd_pkg::REG_W-1:0] a_reg, b_reg, d_reg;

  assign a_reg = in_tdata[hzd_pkg::IN_A_REG +: hzd_pkg::REG_W];
  assign b_reg = in_tdata[hzd_pkg::IN_B_REG +: hzd_pkg::REG_W];
  assign d_reg = in_tdata[hzd_pkg::IN_D_REG +: hzd_pkg::REG_W];

  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;

  always_comb begin
    q_word.src_a = a_reg;
    q_word.src_b = b_reg;
    q_word.dst   = d_reg;
    q_word.en[0] = in_tdata[hzd_pkg::IN_A_VLD] && (32'(a_reg) < NUM_REGS);
    q_word.en[1] = in_tdata[hzd_pkg::IN_B_VLD] && (32'(b_reg) < NUM_REGS);
    q_word.en[2] = in_tdata[hzd_pkg::IN_D_VLD] && (32'(d_reg) < NUM_REGS);
  end

endmodule
`default_nettype wire

// ===== sv/hzd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hzd_fifo: short instruction queue
// Decouples intake from the record walker.
// ----------------------------------------------------------------------------
module hzd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  hzd_pkg::instr_t      push_word,
  output logic                 push_ready,
  input  wire logic            pop,
  output logic                 pop_valid,
  output hzd_pkg::instr_t      pop_word
);

  localparam int DEPTH = hzd_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  hzd_pkg::instr_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/hzd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hzd_back: access record walker
// Walks the accesses of one instruction against the per-register record,
// one access a cycle while the output is not stalled, and issues
// dependence words through a holding slot so that the final one of each
// instruction can be marked.
module hzd_back #(
  parameter int NUM_REGS   = hzd_pkg::DEF_NUM_REGS,
  parameter int INDEX_BITS = hzd_pkg::DEF_INDEX_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  hzd_pkg::instr_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output hzd_pkg::result_t out_word
);

  localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int ENT_W  = 2 + INDEX_BITS;

  // record: kind in the top two bits, index below
  logic [ENT_W-1:0]    rec_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rec_vld;

  hzd_pkg::back_state_t state, state_next;
  hzd_pkg::instr_t      cur;
  hzd_pkg::slot_t       slot, slot_next;
  logic [INDEX_BITS-1:0] instr_count;

  logic [ENT_W-1:0] rd_data, hit_data;
  logic             rd_hit, rd_vbit;

  logic             pend_valid;
  hzd_pkg::result_t pend, new_res, out_load_word;

  logic load_cur, rd_re, rec_we, count_inc, out_load, pend_load, pend_clear;
  logic [hzd_pkg::REG_W-1:0] rd_sel_reg, eval_reg;
  logic [REG_AW-1:0]         raddr, waddr;
  logic [ENT_W-1:0]          wdata;

  hzd_pkg::acc_kind_t    eff_kind;
  logic [INDEX_BITS-1:0] eff_index;
  logic                  is_write, emits, stall, out_free;
  logic                  first_found, next_found;
  hzd_pkg::slot_t        first_slot, next_slot;

  function automatic logic [hzd_pkg::REG_W-1:0] slot_reg(hzd_pkg::instr_t i,
                                                          hzd_pkg::slot_t s);
    logic [hzd_pkg::REG_W-1:0] r;
    case (s)
      hzd_pkg::SLOT_A: r = i.src_a;
      hzd_pkg::SLOT_B: r = i.src_b;
      default:         r = i.dst;
    endcase
    return r;
  endfunction

  // enables at or after a given slot
  function automatic logic [2:0] en_from(logic [2:0] en, logic [1:0] from);
    logic [2:0] m;
    case (from)
      2'd0:    m = 3'b111;
      2'd1:    m = 3'b110;
      2'd2:    m = 3'b100;
      default: m = 3'b000;
    endcase
    return en & m;
  endfunction

  function automatic hzd_pkg::slot_t first_of(logic [2:0] en);
    hzd_pkg::slot_t s;
    if (en[0]) begin
      s = hzd_pkg::SLOT_A;
    end else if (en[1]) begin
      s = hzd_pkg::SLOT_B;
    end else begin
      s = hzd_pkg::SLOT_D;
    end
    return s;
  endfunction

  logic [2:0] first_en, next_en;

  assign first_en    = en_from(q_data.en, 2'd0);
  assign first_found = |first_en;
  assign first_slot  = first_of(first_en);
  assign next_en     = en_from(cur.en, 2'(slot) + 2'd1);
  assign next_found  = |next_en;
  assign next_slot   = first_of(next_en);

  // effective record entry: same-cycle write wins, unwritten reads as none
  always_comb begin
    if (rd_hit) begin
      eff_kind  = hzd_pkg::acc_kind_t'(hit_data[ENT_W-1 -: 2]);
      eff_index = hit_data[INDEX_BITS-1:0];
    end else if (rd_vbit) begin
      eff_kind  = hzd_pkg::acc_kind_t'(rd_data[ENT_W-1 -: 2]);
      eff_index = rd_data[INDEX_BITS-1:0];
    end else begin
      eff_kind  = hzd_pkg::ACC_NONE;
      eff_index = '0;
    end
  end

  assign eval_reg = slot_reg(cur, slot);
  assign is_write = (slot == hzd_pkg::SLOT_D);
  assign emits    = is_write ? (eff_kind != hzd_pkg::ACC_NONE)
                             : (eff_kind == hzd_pkg::ACC_WRITE);
  assign out_free = !out_valid || out_ready;
  assign stall    = emits && pend_valid && !out_free;

  always_comb begin
    new_res.hreg    = eval_reg;
    new_res.earlier = hzd_pkg::OUT_IDX_W'(eff_index);
    new_res.later   = hzd_pkg::OUT_IDX_W'(instr_count);
    new_res.last    = 1'b0;
    if (!is_write) begin
      new_res.kind = hzd_pkg::HZ_RAW;
    end else if (eff_kind == hzd_pkg::ACC_WRITE) begin
      new_res.kind = hzd_pkg::HZ_WAW;
    end else begin
      new_res.kind = hzd_pkg::HZ_WAR;
    end
  end

  assign waddr = REG_AW'(eval_reg);
  assign wdata = {(is_write ? hzd_pkg::ACC_WRITE : hzd_pkg::ACC_READ), instr_count};
  assign raddr = REG_AW'(rd_sel_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hzd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    load_cur      = 1'b0;
    rd_re         = 1'b0;
    rd_sel_reg    = '0;
    slot_next     = slot;
    rec_we        = 1'b0;
    count_inc     = 1'b0;
    out_load      = 1'b0;
    out_load_word = pend;
    pend_load     = 1'b0;
    pend_clear    = 1'b0;
    unique case (state)
      hzd_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          load_cur = 1'b1;
          if (first_found) begin
            rd_re      = 1'b1;
            rd_sel_reg = slot_reg(q_data, first_slot);
            slot_next  = first_slot;
            state_next = hzd_pkg::BK_EVAL;
          end else begin
            count_inc = 1'b1;
          end
        end
      end
      hzd_pkg::BK_EVAL: begin
        if (!stall) begin
          rec_we = 1'b1;
          if (emits) begin
            pend_load = 1'b1;
            if (pend_valid) begin
              out_load = 1'b1;
            end
          end
          if (next_found) begin
            rd_re      = 1'b1;
            rd_sel_reg = slot_reg(cur, next_slot);
            slot_next  = next_slot;
          end else begin
            count_inc  = 1'b1;
            state_next = hzd_pkg::BK_FLUSH;
          end
        end
      end
      hzd_pkg::BK_FLUSH: begin
        if (!pend_valid) begin
          state_next = hzd_pkg::BK_IDLE;
        end else if (out_free) begin
          out_load           = 1'b1;
          out_load_word.last = 1'b1;
          pend_clear         = 1'b1;
          state_next         = hzd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = hzd_pkg::BK_IDLE;
      end
    endcase
  end

  // record store
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[waddr] <= wdata;
    end
    if (rd_re) begin
      rd_data <= rec_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_vld     <= '0;
      rd_hit      <= 1'b0;
      rd_vbit     <= 1'b0;
      slot        <= hzd_pkg::SLOT_A;
      instr_count <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (rec_we) begin
        rec_vld[waddr] <= 1'b1;
      end
      if (rd_re) begin
        rd_hit  <= rec_we && (waddr == raddr);
        rd_vbit <= rec_vld[raddr];
      end
      slot <= slot_next;
      if (count_inc) begin
        instr_count <= instr_count + INDEX_BITS'(1);
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_re) begin
      hit_data <= wdata;
    end
    if (load_cur) begin
      cur <= q_data;
    end
    if (pend_load) begin
      pend <= new_res;
    end
    if (out_load) begin
      out_word <= out_load_word;
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == hzd_pkg::BK_IDLE |-> !rec_we)
    else $error("record written outside evaluation");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == hzd_pkg::BK_IDLE |-> !pend_valid)
    else $error("held word left over from previous instruction");

  a_eval_slot_en: assert property (@(posedge clk) disable iff (rst)
    state == hzd_pkg::BK_EVAL |-> cur.en[slot])
    else $error("evaluating a disabled access");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == hzd_pkg::BK_EVAL && state_next == hzd_pkg::BK_FLUSH)
    |=> instr_count == $past(instr_count) + INDEX_BITS'(1))
    else $error("instruction index did not advance at end of instruction");

endmodule
`default_nettype wire

// ===== sv/register_hazard_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// register_hazard_detector: RAW / WAR / WAW register dependence finder
// Top level: intake, queue and record walker.
// ----------------------------------------------------------------------------
// Each input word is one decoded instruction (source A, source B, destination,
// each with a valid flag). Accesses are checked in the order source A, source
// B, destination against a per-register record of the last access kind and
// the index of the instruction that made it; each check updates the record at
// once, so a destination equal to a source reports WAR against the same
// instruction. Accesses to registers at or above NUM_REGS are ignored. Zero to
// three dependence words come out per instruction, tlast marking the final
// one. An instruction with valid in-range accesses occupies the record walker
// for a pop, one step per access through the single read port of the record
// memory and a step to release the held final word; one with no accesses is
// only popped and counted. A two-deep queue lets intake continue while the
// walker is busy, and the output register lets the walker carry on while a
// word waits to be taken; back-pressure on the output stalls the walker only
// when a second word is ready. The record is valid straight after reset: no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module register_hazard_detector #(
  parameter int NUM_REGS   = hzd_pkg::DEF_NUM_REGS,
  parameter int INDEX_BITS = hzd_pkg::DEF_INDEX_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // slave: instruction words
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] src_a_valid, [5:1] src_a_reg, [6] src_b_valid, [11:7] src_b_reg,
  // [12] dst_valid, [17:13] dst_reg, [23:18] zero
  input  wire logic [hzd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // master: dependence words
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [4:0] hazard_reg, [20:5] earlier_index, [36:21] later_index, [39:37] zero
  output logic [hzd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // [1:0] hazard_kind (0 RAW, 1 WAR, 2 WAW)
  output logic [1:0]                          m_axis_tuser,
  // last_of_run
  output logic                                m_axis_tlast
);

  hzd_pkg::instr_t  push_word, pop_word;
  logic             q_ready, q_push, q_valid, q_pop;
  hzd_pkg::result_t res;

  // intake and classification
  hzd_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .in_tdata  (s_axis_tdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_word    (push_word)
  );

  // instruction queue between intake and walker
  hzd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_word  (push_word),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_word   (pop_word)
  );

  // record walker and output register
  hzd_back #(
    .NUM_REGS   (NUM_REGS),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (pop_word),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (res)
  );

  // output word packing
  assign m_axis_tdata = {{hzd_pkg::OUT_PAD_W{1'b0}}, res.later, res.earlier, res.hreg};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

// ===== tb/hazard_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hazard_checker: dependence predictor and scoreboard
// Watches both stream channels of the hazard detector. Every accepted
// instruction word runs through a local copy of the access record and queues
// the dependence words it should cause. Every accepted result word is checked
// against the oldest of those.
// ----------------------------------------------------------------------------
module hazard_checker #(
  parameter int NUM_REGS   = hzd_pkg::DEF_NUM_REGS,
  parameter int INDEX_BITS = hzd_pkg::DEF_INDEX_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [hzd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [hzd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [1:0]                      m_axis_tuser,
  input  logic                            m_axis_tlast,
  output int                              mismatches,
  output int                              outstanding
);

  hzd_pkg::acc_kind_t    rec_kind  [NUM_REGS];
  logic [INDEX_BITS-1:0] rec_index [NUM_REGS];
  logic [INDEX_BITS-1:0] instr_idx;
  hzd_pkg::result_t      due_words [$];
  int                    fail_cnt = 0;

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t hazard check: %s", $realtime, msg);
  endfunction

  // walk source A, source B, destination; record updated after each access
  function automatic void predict_hazards(input logic [hzd_pkg::IN_TDATA_W-1:0] w);
    logic [2:0]                en;
    logic [hzd_pkg::REG_W-1:0] regs [3];
    logic [hzd_pkg::REG_W-1:0] r;
    hzd_pkg::result_t          hits [3];
    hzd_pkg::result_t          h;
    int                        n;
    int                        k;
    en      = {w[hzd_pkg::IN_D_VLD], w[hzd_pkg::IN_B_VLD], w[hzd_pkg::IN_A_VLD]};
    regs[0] = w[hzd_pkg::IN_A_REG +: hzd_pkg::REG_W];
    regs[1] = w[hzd_pkg::IN_B_REG +: hzd_pkg::REG_W];
    regs[2] = w[hzd_pkg::IN_D_REG +: hzd_pkg::REG_W];
    n = 0;
    for (k = 0; k < 3; k++) begin
      r = regs[k];
      if (en[k] && int'(r) < NUM_REGS) begin
        h.hreg    = r;
        h.earlier = hzd_pkg::OUT_IDX_W'(rec_index[r]);
        h.later   = hzd_pkg::OUT_IDX_W'(instr_idx);
        h.last    = 1'b0;
        if (k == 2) begin
          if (rec_kind[r] == hzd_pkg::ACC_WRITE) begin
            h.kind  = hzd_pkg::HZ_WAW;
            hits[n] = h;
            n++;
          end else if (rec_kind[r] == hzd_pkg::ACC_READ) begin
            h.kind  = hzd_pkg::HZ_WAR;
            hits[n] = h;
            n++;
          end
          rec_kind[r] = hzd_pkg::ACC_WRITE;
        end else begin
          if (rec_kind[r] == hzd_pkg::ACC_WRITE) begin
            h.kind  = hzd_pkg::HZ_RAW;
            hits[n] = h;
            n++;
          end
          rec_kind[r] = hzd_pkg::ACC_READ;
        end
        rec_index[r] = instr_idx;
      end
    end
    for (k = 0; k < n; k++) begin
      h      = hits[k];
      h.last = (k == n - 1);
      due_words.insert(due_words.size(), h);
    end
    instr_idx = instr_idx + 1'b1;
  endfunction

  function automatic void check_word();
    hzd_pkg::result_t              want;
    logic [hzd_pkg::REG_W-1:0]     got_reg;
    logic [hzd_pkg::OUT_IDX_W-1:0] got_earlier;
    logic [hzd_pkg::OUT_IDX_W-1:0] got_later;
    got_reg     = m_axis_tdata[hzd_pkg::REG_W-1:0];
    got_earlier = m_axis_tdata[hzd_pkg::REG_W +: hzd_pkg::OUT_IDX_W];
    got_later   = m_axis_tdata[hzd_pkg::REG_W + hzd_pkg::OUT_IDX_W +: hzd_pkg::OUT_IDX_W];
    if (due_words.size() == 0) begin
      note_failure($sformatf("unexpected word kind %0d reg %0d earlier %0d later %0d last %0b",
                             m_axis_tuser, got_reg, got_earlier, got_later, m_axis_tlast));
      return;
    end
    want = due_words.pop_front();
    if (m_axis_tuser !== want.kind || got_reg !== want.hreg ||
        got_earlier !== want.earlier || got_later !== want.later ||
        m_axis_tlast !== want.last)
      note_failure($sformatf({"expected kind %0d reg %0d earlier %0d later %0d last %0b, ",
                              "got kind %0d reg %0d earlier %0d later %0d last %0b"},
                             want.kind, want.hreg, want.earlier, want.later, want.last,
                             m_axis_tuser, got_reg, got_earlier, got_later, m_axis_tlast));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) rec_kind[k] = hzd_pkg::ACC_NONE;
      instr_idx = '0;
      due_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (s_axis_tvalid && s_axis_tready) predict_hazards(s_axis_tdata);
    end
    mismatches  <= fail_cnt;
    outstanding <= due_words.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: register hazard detector stimulus and verdict
// Drives decoded instruction words into the detector: a directed set of
// dependence cases, then random instructions over small register pools. Both
// sides idle at random; the receiver also holds off once for a long stretch so
// the detector fills and stalls its input. The checker does all the comparing.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_REGS   = hzd_pkg::DEF_NUM_REGS;
  localparam int INDEX_BITS = hzd_pkg::DEF_INDEX_BITS;
  localparam int RAND_ITEMS = 207;
  localparam int BLOCK_LEN  = 23;
  localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles

  logic                                clk           = 1'b0;
  logic                                rst           = 1'b1;
  logic                                s_axis_tvalid = 1'b0;
  logic [hzd_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;
  logic                                m_axis_tready = 1'b0;
  wire                                 s_axis_tready;
  wire                                 m_axis_tvalid;
  wire [hzd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata;
  wire [1:0]                           m_axis_tuser;
  wire                                 m_axis_tlast;

  int                        mismatches;
  int                        outstanding;
  bit                        no_idle   = 1'b0;  // both sides run flat out while set
  bit                        hold_req  = 1'b0;
  logic                      hold      = 1'b0;
  logic [hzd_pkg::REG_W-1:0] pool_base = '0;    // base of the current small register pool
  int                        rx_gap    = 0;
  int                        rx_draw;

  always #5 clk = ~clk;

  register_hazard_detector #(
    .NUM_REGS   (NUM_REGS),
    .INDEX_BITS (INDEX_BITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hazard_checker #(
    .NUM_REGS   (NUM_REGS),
    .INDEX_BITS (INDEX_BITS)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // pad bits [23:18] stay zero
  function automatic logic [hzd_pkg::IN_TDATA_W-1:0] pack_instr(
    input bit av, input logic [hzd_pkg::REG_W-1:0] ar,
    input bit bv, input logic [hzd_pkg::REG_W-1:0] br,
    input bit dv, input logic [hzd_pkg::REG_W-1:0] dr
  );
    logic [hzd_pkg::IN_TDATA_W-1:0] w;
    w                                        = '0;
    w[hzd_pkg::IN_A_VLD]                     = av;
    w[hzd_pkg::IN_A_REG +: hzd_pkg::REG_W]   = ar;
    w[hzd_pkg::IN_B_VLD]                     = bv;
    w[hzd_pkg::IN_B_REG +: hzd_pkg::REG_W]   = br;
    w[hzd_pkg::IN_D_VLD]                     = dv;
    w[hzd_pkg::IN_D_REG +: hzd_pkg::REG_W]   = dr;
    return w;
  endfunction

  // mostly a four-register pool so that dependences are common; now and then
  // the whole register range and fully random flags
  function automatic logic [hzd_pkg::REG_W-1:0] pick_reg(input bit wide);
    if (wide) return hzd_pkg::REG_W'($urandom);
    return pool_base + hzd_pkg::REG_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [hzd_pkg::IN_TDATA_W-1:0] rand_instr();
    int mode;
    bit wide;
    bit coin;
    mode = $urandom_range(0, 9);
    wide = (mode >= 7);
    coin = (mode == 9);
    return pack_instr(coin ? 1'($urandom) : ($urandom_range(0, 3) != 0), pick_reg(wide),
                      coin ? 1'($urandom) : ($urandom_range(0, 3) != 0), pick_reg(wide),
                      coin ? 1'($urandom) : ($urandom_range(0, 3) != 0), pick_reg(wide));
  endfunction

  // offer one word after a random gap and hold it until taken; called at
  // the edge where the previous word went in
  task automatic send_instr(input logic [hzd_pkg::IN_TDATA_W-1:0] w);
    int g;
    g = no_idle ? 0 : $urandom_range(0, 3);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // receiver: random gap before each word, forced low on hold
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rx_draw = no_idle ? 0 : $urandom_range(0, 3);
      m_axis_tready <= (rx_draw == 0) && !hold;
      rx_gap        <= (rx_draw == 0) ? 0 : rx_draw - 1;
    end else if (hold) begin
      m_axis_tready <= 1'b0;
    end else if (!m_axis_tready) begin
      if (rx_gap == 0) m_axis_tready <= 1'b1;
      else rx_gap <= rx_gap - 1;
    end
  end

  // long hold-off on the result side while the sender keeps offering words
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: indices 0 upwards
    send_instr(pack_instr(0, 5'd31, 0, 5'd31, 0, 5'd31)); // nothing valid
    send_instr(pack_instr(0, 5'd0,  0, 5'd0,  1, 5'd0));  // first write, no record
    send_instr(pack_instr(1, 5'd0,  0, 5'd31, 0, 5'd31)); // RAW on r0
    send_instr(pack_instr(1, 5'd0,  1, 5'd0,  0, 5'd0));  // read after read, silent
    send_instr(pack_instr(0, 5'd0,  0, 5'd0,  1, 5'd0));  // WAR on r0
    send_instr(pack_instr(0, 5'd31, 0, 5'd31, 1, 5'd0));  // WAW on r0
    send_instr(pack_instr(1, 5'd31, 0, 5'd0,  1, 5'd31)); // WAR against itself
    send_instr(pack_instr(1, 5'd31, 1, 5'd31, 1, 5'd31)); // RAW then WAR on itself
    send_instr(pack_instr(0, 5'd0,  0, 5'd0,  1, 5'd5));
    send_instr(pack_instr(0, 5'd0,  0, 5'd0,  1, 5'd6));
    send_instr(pack_instr(1, 5'd5,  1, 5'd6,  1, 5'd31)); // three words in one run
    send_instr(pack_instr(0, 5'd5,  1, 5'd0,  0, 5'd6));  // source B alone: RAW r0
    send_instr(pack_instr(0, 5'd6,  0, 5'd5,  0, 5'd31)); // flags low on written regs
    send_instr(pack_instr(0, 5'd0,  0, 5'd0,  1, 5'd6));  // WAR on r6
    send_instr(pack_instr(0, 5'd0,  1, 5'd6,  1, 5'd5));  // RAW r6, WAR r5
    send_instr(pack_instr(1, 5'd16, 1, 5'd15, 1, 5'd16)); // fresh regs, WAR on itself
    send_instr(pack_instr(1, 5'd16, 0, 5'd0,  0, 5'd0));  // RAW r16

    // random instructions in blocks with fresh pools
    for (int b = 0; b * BLOCK_LEN < RAND_ITEMS; b++) begin
      no_idle   = ($urandom_range(0, 3) == 0);
      pool_base = hzd_pkg::REG_W'($urandom);
      if (b == 2) hold_req = 1'b1;
      for (int i = 0; i < BLOCK_LEN; i++) send_instr(rand_instr());
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog: well beyond the slowest legal run
  initial begin
    #(64'd10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/hzd_pkg.sv
sv/hzd_front.sv
sv/hzd_fifo.sv
sv/hzd_back.sv
sv/register_hazard_detector.sv
tb/hazard_checker.sv
tb/testbench.sv
